// File: src/current_reading_moving_average_macros.svh
// Assertion macros for the current reading moving average block.
// Included by the RTL files that carry assertions; needs clk and arst_n in scope.
`ifndef CURRENT_READING_MOVING_AVERAGE_MACROS_SVH
`define CURRENT_READING_MOVING_AVERAGE_MACROS_SVH

`ifndef ASSERT_OFF
// plain property, sampled on clk, off during reset
`define CRMA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// same-cycle implication
`define CRMA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define CRMA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CRMA_ASSERT(label, prop, msg)
`define CRMA_ASSERT_IMP(label, ante, cons, msg)
`define CRMA_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: src/crma_pkg.sv
// Shared types and constants for the current reading moving average block.
// No dependencies; used by every module in src.
package crma_pkg;

	localparam int NUM_CHARS = 7;
	localparam int CHAR_W = 8;
	localparam int VALUE_W = 24;
	localparam int WINDOW_LENGTH_DEF = 8;

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'd48;
	localparam logic [CHAR_W-1:0] CHAR_NINE = 8'd57;
	localparam logic [VALUE_W-1:0] MAX_READING = 24'd9999999;

	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [VALUE_W-1:0] value_t;

	// control handed from the pipeline to every window cell
	typedef struct packed {
		logic load;   // a valid reading moves into the window this cycle
		logic prime;  // first valid reading: every cell takes it
	} cell_ctrl_t;

endpackage

// File: src/crma_decode.sv
// Turns seven ASCII characters into a reading in thousandths.
// Depends on crma_pkg.
module crma_decode (
	input  crma_pkg::char_t  chars [crma_pkg::NUM_CHARS],
	output logic             ok,
	output crma_pkg::value_t value
);

	// place value of each character, thousands digit first
	localparam crma_pkg::value_t DIGIT_WEIGHT [crma_pkg::NUM_CHARS] = '{
		24'd1000000, 24'd100000, 24'd10000, 24'd1000, 24'd100, 24'd10, 24'd1
	};

	logic             all_digits;
	crma_pkg::value_t acc;

	always_comb begin
		crma_pkg::char_t diff;
		all_digits = 1'b1;
		acc = '0;
		for (int k = 0; k < crma_pkg::NUM_CHARS; k++) begin
			diff = chars[k] - crma_pkg::CHAR_ZERO;
			if (chars[k] < crma_pkg::CHAR_ZERO || chars[k] > crma_pkg::CHAR_NINE) begin
				all_digits = 1'b0;
			end
			acc = acc + crma_pkg::VALUE_W'(diff[3:0]) * DIGIT_WEIGHT[k];
		end
	end

	assign ok = all_digits;
	assign value = all_digits ? acc : '0;

endmodule

// File: src/crma_cell.sv
// One entry of the averaging window; loads its left neighbor or, on priming,
// the new reading. Depends on crma_pkg.
module crma_cell (
	input  logic                clk,
	input  crma_pkg::cell_ctrl_t ctrl,
	input  crma_pkg::value_t    reading,
	input  crma_pkg::value_t    prev,
	output crma_pkg::value_t    value
);

	crma_pkg::value_t value_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			value_q <= ctrl.prime ? reading : prev;
		end
	end

	assign value = value_q;

endmodule

// File: src/crma_recip.sv
// Divides the running sum by the window length with a registered multiply by
// a rounded-up reciprocal; exact for every sum below 2**SUM_W. Depends on crma_pkg.
module crma_recip #(
	parameter int WINDOW_LENGTH = crma_pkg::WINDOW_LENGTH_DEF,
	parameter int SUM_W = 27
) (
	input  logic             clk,
	input  logic             load,
	input  logic [SUM_W-1:0] sum,
	output crma_pkg::value_t average
);

	localparam int LOG_W = $clog2(WINDOW_LENGTH);
	localparam int DIV_S = SUM_W + LOG_W;
	localparam int DIV_M_W = SUM_W + 1;
	localparam int PROD_W = SUM_W + DIV_M_W;
	localparam logic [63:0] DIV_M_FULL =
		((64'd1 << DIV_S) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);
	localparam logic [DIV_M_W-1:0] DIV_M = DIV_M_FULL[DIV_M_W-1:0];

	logic [PROD_W-1:0] prod_s3;
	logic [PROD_W-1:0] quot;

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s3 <= PROD_W'(sum) * PROD_W'(DIV_M);
		end
	end

	assign quot = prod_s3 >> DIV_S;
	assign average = quot[crma_pkg::VALUE_W-1:0];

endmodule

// File: src/current_reading_moving_average.sv
// Current reading moving average: ASCII reading decode, window of cells, average.
// Depends on crma_pkg, crma_decode, crma_cell, crma_recip and the macros header.
//
// Usage:
//   Input channel: in_valid/in_stall carry one reading as seven ASCII characters
//   char_0..char_6 (four integer digits, then three fraction digits).
//   Output channel: out_valid/out_stall carry reading_ok, reading_value and
//   average_value, all in thousandths; a rejected reading gives all zeros and
//   leaves the window untouched.
//   A transaction on either side completes on a rising edge with valid high and
//   stall low. Every reading gives exactly one result.
//   The result passes in order through the decode register, the window update
//   and the reciprocal multiply before it is presented on the output channel.
//   Throughput: one reading per cycle while out_stall stays low; the window cells
//   and the running sum update together; the divide is one pipelined multiply.
//   A stalled receiver holds the result; the three stages keep filling, and
//   in_stall rises only when the first stage is full and cannot move on.
//   Reset (arst_n low) empties the pipeline and unprimes the window; the first
//   valid reading after reset fills every window cell with itself.
module current_reading_moving_average #(
	parameter int WINDOW_LENGTH = crma_pkg::WINDOW_LENGTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  crma_pkg::char_t  char_0,
	input  crma_pkg::char_t  char_1,
	input  crma_pkg::char_t  char_2,
	input  crma_pkg::char_t  char_3,
	input  crma_pkg::char_t  char_4,
	input  crma_pkg::char_t  char_5,
	input  crma_pkg::char_t  char_6,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             reading_ok,
	output crma_pkg::value_t reading_value,
	output crma_pkg::value_t average_value
);

`include "current_reading_moving_average_macros.svh"

	localparam int SUM_W =
		$clog2(WINDOW_LENGTH * int'(crma_pkg::MAX_READING) + 1);

	crma_pkg::char_t  chars [crma_pkg::NUM_CHARS];
	logic             dec_ok;
	crma_pkg::value_t dec_value;

	logic v_s1, v_s2, v_s3;
	logic ok_s1, ok_s2, ok_s3;
	crma_pkg::value_t x_s1, x_s2, x_s3;

	logic take2, take3, accept;

	logic             primed_q;
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] sum_next;

	crma_pkg::cell_ctrl_t cell_ctrl;
	crma_pkg::value_t     cell_val [WINDOW_LENGTH];
	logic [SUM_W-1:0]     recip_sum;

	assign chars[0] = char_0;
	assign chars[1] = char_1;
	assign chars[2] = char_2;
	assign chars[3] = char_3;
	assign chars[4] = char_4;
	assign chars[5] = char_5;
	assign chars[6] = char_6;

	crma_decode u_decode (
		.chars (chars),
		.ok    (dec_ok),
		.value (dec_value)
	);

	// stage handoff: a stage takes new data when empty or when it moves on
	assign take3 = !v_s3 || !out_stall;
	assign take2 = !v_s2 || take3;
	assign in_stall = v_s1 && !take2;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (!in_stall) v_s1 <= in_valid;
			if (take2) v_s2 <= v_s1;
			if (take3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_s1 <= dec_ok;
			x_s1 <= dec_value;
		end
		if (take2) begin
			ok_s2 <= ok_s1;
			x_s2 <= x_s1;
		end
		if (take3) begin
			ok_s3 <= ok_s2;
			x_s3 <= x_s2;
		end
	end

	// window update as a valid reading moves from stage 1 to stage 2
	assign cell_ctrl.load = take2 && v_s1 && ok_s1;
	assign cell_ctrl.prime = !primed_q;

	for (genvar i = 0; i < WINDOW_LENGTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			crma_cell u_cell (
				.clk     (clk),
				.ctrl    (cell_ctrl),
				.reading (x_s1),
				.prev    (x_s1),
				.value   (cell_val[i])
			);
		end else begin : g_body
			crma_cell u_cell (
				.clk     (clk),
				.ctrl    (cell_ctrl),
				.reading (x_s1),
				.prev    (cell_val[i-1]),
				.value   (cell_val[i])
			);
		end
	end

	// last cell holds the oldest reading
	assign sum_next = primed_q
		? sum_q - SUM_W'(cell_val[WINDOW_LENGTH-1]) + SUM_W'(x_s1)
		: SUM_W'(x_s1) * SUM_W'(WINDOW_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
			sum_q <= '0;
		end else if (cell_ctrl.load) begin
			primed_q <= 1'b1;
			sum_q <= sum_next;
		end
	end

	// sum_q belongs to the reading in stage 2 until that reading leaves
	assign recip_sum = ok_s2 ? sum_q : '0;

	crma_recip #(
		.WINDOW_LENGTH (WINDOW_LENGTH),
		.SUM_W         (SUM_W)
	) u_recip (
		.clk     (clk),
		.load    (take3),
		.sum     (recip_sum),
		.average (average_value)
	);

	assign out_valid = v_s3;
	assign reading_ok = ok_s3;
	assign reading_value = x_s3;

	`CRMA_ASSERT_NEXT(a_reject_keeps_state, take2 && v_s1 && !ok_s1,
		$stable(sum_q) && $stable(primed_q), "rejected reading changed window state")
	`CRMA_ASSERT_NEXT(a_primed_sticks, primed_q, primed_q, "window lost its primed flag")
	`CRMA_ASSERT_IMP(a_reject_zero, out_valid && !reading_ok,
		reading_value == '0 && average_value == '0, "rejected result is not zero")
	`CRMA_ASSERT_IMP(a_avg_range, out_valid,
		average_value <= crma_pkg::MAX_READING, "average out of reading range")

endmodule

// File: sim/tb_top.sv
// Testbench for current_reading_moving_average: directed and random ASCII readings,
// checked against an in-bench window predictor with random input gaps and output stalls.
// Depends on crma_pkg and the RTL under src.
`timescale 1ns / 100ps

module tb_top;

	localparam int WL = crma_pkg::WINDOW_LENGTH_DEF;
	localparam int SUM_W = crma_pkg::VALUE_W + $clog2(WL);
	localparam int RANDOM_READINGS = 1800;
	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_MAX = 10;
	localparam int DRAIN_CYCLES = 10;

	typedef logic [crma_pkg::NUM_CHARS-1:0][crma_pkg::CHAR_W-1:0] reading_chars_t;

	typedef struct packed {
		logic             ok;
		crma_pkg::value_t reading;
		crma_pkg::value_t average;
	} result_t;

	typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_HOLD} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	crma_pkg::char_t char_0 = '0, char_1 = '0, char_2 = '0, char_3 = '0;
	crma_pkg::char_t char_4 = '0, char_5 = '0, char_6 = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic reading_ok;
	crma_pkg::value_t reading_value;
	crma_pkg::value_t average_value;

	// window predictor state
	logic win_primed = 1'b0;
	crma_pkg::value_t win_cells [WL];
	int unsigned win_ptr = 0;
	logic [SUM_W-1:0] win_sum = '0;

	reading_chars_t readings_q[$];
	result_t results_due_q[$];
	reading_chars_t next_chars;

	logic in_fire = 1'b0;
	int tx_burst_left = 0;
	int tx_gap_left = 0;
	int rx_seg_left = 0;
	int rx_seg_count = 0;
	rx_mode_t rx_mode = RX_FREE;
	int mismatch_count = 0;
	int cycle_count = 0;

	current_reading_moving_average dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.char_0        (char_0),
		.char_1        (char_1),
		.char_2        (char_2),
		.char_3        (char_3),
		.char_4        (char_4),
		.char_5        (char_5),
		.char_6        (char_6),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.reading_ok    (reading_ok),
		.reading_value (reading_value),
		.average_value (average_value)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Decode one reading and fold it into the predicted window.
	function automatic result_t fold_reading(reading_chars_t ch);
		result_t res;
		int unsigned acc;
		logic ok;
		acc = 0;
		ok = 1'b1;
		for (int k = 0; k < crma_pkg::NUM_CHARS; k++) begin
			if (ch[k] < crma_pkg::CHAR_ZERO || ch[k] > crma_pkg::CHAR_NINE)
				ok = 1'b0;
			else
				acc = acc * 10 + (ch[k] - crma_pkg::CHAR_ZERO);
		end
		res = '0;
		if (ok) begin
			if (!win_primed) begin
				for (int i = 0; i < WL; i++)
					win_cells[i] = crma_pkg::value_t'(acc);
				win_sum = SUM_W'(acc * WL);
				win_ptr = 0;
				win_primed = 1'b1;
			end else begin
				win_sum = win_sum - win_cells[win_ptr] + SUM_W'(acc);
				win_cells[win_ptr] = crma_pkg::value_t'(acc);
				win_ptr = (win_ptr == WL - 1) ? 0 : win_ptr + 1;
			end
			res.ok = 1'b1;
			res.reading = crma_pkg::value_t'(acc);
			res.average = crma_pkg::value_t'(win_sum / WL);
		end
		return res;
	endfunction

	function automatic reading_chars_t chars_of(string s);
		reading_chars_t ch;
		for (int k = 0; k < crma_pkg::NUM_CHARS; k++)
			ch[k] = crma_pkg::char_t'(s[k]);
		return ch;
	endfunction

	// sender: bursts of transactions with random gaps, payload held while stalled
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fire)) begin
			if (tx_gap_left != 0) begin
				in_valid <= 1'b0;
				tx_gap_left <= tx_gap_left - 1;
			end else if (readings_q.size() != 0) begin
				next_chars = readings_q.pop_front();
				char_0 <= next_chars[0];
				char_1 <= next_chars[1];
				char_2 <= next_chars[2];
				char_3 <= next_chars[3];
				char_4 <= next_chars[4];
				char_5 <= next_chars[5];
				char_6 <= next_chars[6];
				in_valid <= 1'b1;
				if (tx_burst_left <= 1) begin
					tx_burst_left <= $urandom_range(1, 24);
					tx_gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					tx_burst_left <= tx_burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern chosen per segment; one early segment is a long hold-off
	always @(negedge clk) begin
		if (rx_seg_left == 0) begin
			rx_seg_left <= $urandom_range(40, 160);
			rx_mode <= (rx_seg_count == 2) ? RX_HOLD : rx_mode_t'($urandom_range(0, 3));
			rx_seg_count <= rx_seg_count + 1;
		end else begin
			rx_seg_left <= rx_seg_left - 1;
		end
		case (rx_mode)
			RX_FREE:  out_stall <= 1'b0;
			RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default:  out_stall <= 1'b1;
		endcase
	end

	// monitor: predict on input transactions, check output transactions
	always @(posedge clk) begin
		if (!arst_n) begin
			in_fire <= 1'b0;
		end else begin
			in_fire <= in_valid && !in_stall;
			if (out_valid && !out_stall) begin
				if (results_due_q.size() == 0) begin
					if (mismatch_count < REPORT_MAX)
						$display("unexpected result: ok=%0b reading=%0d average=%0d",
							reading_ok, reading_value, average_value);
					mismatch_count++;
				end else begin
					result_t want;
					want = results_due_q.pop_front();
					if (reading_ok !== want.ok || reading_value !== want.reading ||
							average_value !== want.average) begin
						if (mismatch_count < REPORT_MAX)
							$display("mismatch: exp %0b/%0d/%0d got %0b/%0d/%0d",
								want.ok, want.reading, want.average,
								reading_ok, reading_value, average_value);
						mismatch_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				results_due_q.push_back(fold_reading({char_6, char_5, char_4, char_3,
					char_2, char_1, char_0}));
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		reading_chars_t ch;
		int pick;
		// rejects before the window is primed: all-ones, just below '0', just above '9'
		readings_q.push_back({crma_pkg::NUM_CHARS{8'hFF}});
		readings_q.push_back(chars_of("12345/7"));
		readings_q.push_back(chars_of(":234567"));
		// first good reading primes the whole window
		readings_q.push_back(chars_of("1234567"));
		readings_q.push_back(chars_of("9999999"));
		readings_q.push_back(chars_of("0000000"));
		// one bad character at each position after priming
		readings_q.push_back(chars_of("/000000"));
		readings_q.push_back(chars_of("9:99999"));
		readings_q.push_back(chars_of("12a4567"));
		readings_q.push_back(chars_of("123 567"));
		readings_q.push_back(chars_of("1234~67"));
		ch = chars_of("1234567");
		ch[5] = 8'h00;
		readings_q.push_back(ch);
		ch[5] = crma_pkg::CHAR_ZERO;
		ch[6] = 8'h80;
		readings_q.push_back(ch);
		// enough good readings to wrap the ring and hit the sum extremes
		readings_q.push_back(chars_of("0000001"));
		readings_q.push_back(chars_of("9999998"));
		readings_q.push_back(chars_of("5000000"));
		readings_q.push_back(chars_of("0999999"));
		readings_q.push_back(chars_of("9000000"));
		for (int i = 0; i < 8; i++)
			readings_q.push_back(chars_of("9999999"));

		for (int n = 0; n < RANDOM_READINGS; n++) begin
			pick = $urandom_range(0, 99);
			for (int k = 0; k < crma_pkg::NUM_CHARS; k++)
				ch[k] = crma_pkg::CHAR_ZERO + crma_pkg::char_t'($urandom_range(0, 9));
			if (pick < 5) begin
				ch = {crma_pkg::NUM_CHARS{crma_pkg::CHAR_NINE}};
			end else if (pick < 8) begin
				ch = {crma_pkg::NUM_CHARS{crma_pkg::CHAR_ZERO}};
			end else if (pick < 16) begin
				ch[$urandom_range(0, crma_pkg::NUM_CHARS - 1)] =
					crma_pkg::char_t'($urandom_range(0, 255));
			end else if (pick < 20) begin
				for (int k = 0; k < crma_pkg::NUM_CHARS; k++)
					ch[k] = crma_pkg::char_t'($urandom_range(0, 255));
			end
			readings_q.push_back(ch);
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (readings_q.size() != 0 || in_valid)
			@(posedge clk);
		while (results_due_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && results_due_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+src
src/crma_pkg.sv
src/crma_decode.sv
src/crma_cell.sv
src/crma_recip.sv
src/current_reading_moving_average.sv
sim/tb_top.sv
